>>> rtl/csi_pkg.sv
// ----------------------------------------------------------------------------
// csi_pkg
// Shared types, character codes and token literals for the C source space
// inserter.
// ----------------------------------------------------------------------------
package csi_pkg;

	// character codes
	localparam logic [7:0] CH_LF      = 8'h0a;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_STAR    = 8'h2a;
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_COMMA   = 8'h2c;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_SLASH   = 8'h2f;
	localparam logic [7:0] CH_SEMI    = 8'h3b;
	localparam logic [7:0] CH_LT      = 8'h3c;
	localparam logic [7:0] CH_EQ      = 8'h3d;
	localparam logic [7:0] CH_GT      = 8'h3e;
	localparam logic [7:0] CH_BSLASH  = 8'h5c;
	localparam logic [7:0] CH_RBRACK  = 8'h5d;
	localparam logic [7:0] CH_LOWER_E = 8'h65;
	localparam logic [7:0] CH_LBRACE  = 8'h7b;

	// token literals, last character in the lowest byte
	localparam logic [63:0] LIT_HASH_INCLUDE = "#include";
	localparam logic [55:0] LIT_INCLUDE      = "include";
	localparam logic [23:0] LIT_IF           = "if(";
	localparam logic [31:0] LIT_FOR          = "for(";
	localparam logic [47:0] LIT_WHILE        = "while(";
	localparam logic [55:0] LIT_SWITCH       = "switch(";

	// number of line bytes the token matchers look at
	localparam int unsigned TAIL_BYTES = 8;

	// lexical mode
	typedef enum logic [4:0] {
		MODE_NORMAL = 5'b00001,
		MODE_STRING = 5'b00010,
		MODE_CHAR   = 5'b00100,
		MODE_BLOCK  = 5'b01000,
		MODE_LINE   = 5'b10000
	} lex_mode_t;

	// line tracker to spacing rules
	typedef struct packed {
		logic       mode_normal;
		logic [7:0] prev;
		logic       kw_paren;
		logic       deref;
		logic       incdec;
		logic       include_line;
	} line_flags_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_alpha(c) || is_digit(c);
	endfunction

	// operators after which a digit gets a space
	function automatic logic in_ops_digit(input logic [7:0] c);
		return c == CH_SEMI || c == CH_COMMA || c == CH_GT || c == CH_EQ ||
			c == CH_SLASH || c == CH_PERCENT || c == CH_LT;
	endfunction

	// operators after which a letter gets a space
	function automatic logic in_ops_all(input logic [7:0] c);
		return in_ops_digit(c) || c == CH_MINUS || c == CH_PLUS;
	endfunction

endpackage

>>> rtl/csi_line_track.sv
// ----------------------------------------------------------------------------
// csi_line_track
// Lexical mode, previous byte and current-line history; derives the line
// flags that the spacing rules need for the byte in the input register.
// ----------------------------------------------------------------------------
module csi_line_track #(
	parameter int unsigned WINDOW_DEPTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [7:0]           ch,
	output csi_pkg::line_flags_t flags
);

	localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
	localparam int unsigned TB = csi_pkg::TAIL_BYTES;

	logic [7:0]          win_q [WINDOW_DEPTH];
	logic [7:0]          win_n [WINDOW_DEPTH];
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       cnt_n;
	logic                starts_hash_q;
	logic                starts_hash_n;
	logic                hash_inc_q;
	logic                hash_inc_n;
	logic                inc_word_q;
	logic                inc_word_n;
	logic [7:0]          prev_q;
	csi_pkg::lex_mode_t  mode_q;
	csi_pkg::lex_mode_t  mode_n;
	logic [8*TB-1:0]     tail;
	logic                is_lf;

	assign is_lf = (ch == csi_pkg::CH_LF);

	// line history after this byte
	always_comb begin
		win_n[0] = ch;
		for (int i = 1; i < WINDOW_DEPTH; i++) begin
			win_n[i] = win_q[i-1];
		end
		for (int i = 0; i < TB; i++) begin
			tail[8*i +: 8] = win_n[i];
		end
	end

	// line counters and include detection
	always_comb begin
		if (is_lf) begin
			cnt_n         = '0;
			starts_hash_n = 1'b0;
			hash_inc_n    = 1'b0;
			inc_word_n    = 1'b0;
		end else begin
			cnt_n = (cnt_q < CW'(WINDOW_DEPTH)) ? cnt_q + CW'(1) : cnt_q;
			starts_hash_n = (cnt_q == '0) ? (ch == csi_pkg::CH_HASH) : starts_hash_q;
			hash_inc_n = hash_inc_q ||
				(cnt_n >= CW'(8) && tail[63:0] == csi_pkg::LIT_HASH_INCLUDE);
			inc_word_n = inc_word_q ||
				(cnt_n >= CW'(7) && tail[55:0] == csi_pkg::LIT_INCLUDE);
		end
	end

	// lexical mode transition
	always_comb begin
		mode_n = mode_q;
		unique case (mode_q)
			csi_pkg::MODE_NORMAL: begin
				if (ch == csi_pkg::CH_DQUOTE && prev_q != csi_pkg::CH_BSLASH) begin
					mode_n = csi_pkg::MODE_STRING;
				end else if (ch == csi_pkg::CH_SQUOTE && prev_q != csi_pkg::CH_BSLASH) begin
					mode_n = csi_pkg::MODE_CHAR;
				end else if (ch == csi_pkg::CH_STAR && prev_q == csi_pkg::CH_SLASH) begin
					mode_n = csi_pkg::MODE_BLOCK;
				end else if (ch == csi_pkg::CH_SLASH && prev_q == csi_pkg::CH_SLASH) begin
					mode_n = csi_pkg::MODE_LINE;
				end
			end
			csi_pkg::MODE_STRING: begin
				if (ch == csi_pkg::CH_DQUOTE && prev_q != csi_pkg::CH_BSLASH) begin
					mode_n = csi_pkg::MODE_NORMAL;
				end
			end
			csi_pkg::MODE_CHAR: begin
				if (ch == csi_pkg::CH_SQUOTE && prev_q != csi_pkg::CH_BSLASH) begin
					mode_n = csi_pkg::MODE_NORMAL;
				end
			end
			csi_pkg::MODE_LINE: begin
				if (is_lf && prev_q != csi_pkg::CH_BSLASH) begin
					mode_n = csi_pkg::MODE_NORMAL;
				end
			end
			default: begin
				if (ch == csi_pkg::CH_SLASH && prev_q == csi_pkg::CH_STAR) begin
					mode_n = csi_pkg::MODE_NORMAL;
				end
			end
		endcase
	end

	// flags seen by the rules, from the line as it stands after this byte
	always_comb begin
		flags.mode_normal = (mode_q == csi_pkg::MODE_NORMAL);
		flags.prev        = prev_q;
		flags.kw_paren =
			(cnt_n >= CW'(3) && tail[23:0] == csi_pkg::LIT_IF) ||
			(cnt_n >= CW'(4) && tail[31:0] == csi_pkg::LIT_FOR) ||
			(cnt_n >= CW'(6) && tail[47:0] == csi_pkg::LIT_WHILE) ||
			(cnt_n >= CW'(7) && tail[55:0] == csi_pkg::LIT_SWITCH);
		flags.deref = cnt_n >= CW'(3) &&
			win_n[1] == csi_pkg::CH_GT && win_n[2] == csi_pkg::CH_MINUS;
		flags.incdec = cnt_n >= CW'(3) &&
			((win_n[1] == csi_pkg::CH_MINUS && win_n[2] == csi_pkg::CH_MINUS) ||
			 (win_n[1] == csi_pkg::CH_PLUS && win_n[2] == csi_pkg::CH_PLUS));
		flags.include_line = (cnt_n != '0) &&
			(hash_inc_n || (inc_word_n && starts_hash_n));
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= csi_pkg::MODE_NORMAL;
			prev_q        <= '0;
			cnt_q         <= '0;
			starts_hash_q <= 1'b0;
			hash_inc_q    <= 1'b0;
			inc_word_q    <= 1'b0;
		end else if (advance) begin
			mode_q        <= mode_n;
			prev_q        <= ch;
			cnt_q         <= cnt_n;
			starts_hash_q <= starts_hash_n;
			hash_inc_q    <= hash_inc_n;
			inc_word_q    <= inc_word_n;
		end
	end

	// line bytes, only read below the fill count
	always_ff @(posedge clk) begin
		if (advance) begin
			win_q <= win_n;
		end
	end

endmodule

>>> rtl/csi_space_rules.sv
// ----------------------------------------------------------------------------
// csi_space_rules
// Decides whether a space goes in front of the current byte in normal mode.
// ----------------------------------------------------------------------------
module csi_space_rules (
	input  logic                 [7:0] ch,
	input  logic                 [7:0] next_ch,
	input  logic                       next_present,
	input  csi_pkg::line_flags_t       flags,
	output logic                       need_space
);

	logic [7:0] last;
	logic       last_alnum;
	logic       next_digit;
	logic       rule;

	assign last       = flags.prev;
	assign last_alnum = csi_pkg::is_alnum(last);
	assign next_digit = next_present && csi_pkg::is_digit(next_ch);

	// per-character spacing rules, first matching class decides
	always_comb begin
		priority if (ch == csi_pkg::CH_LPAREN) begin
			rule = flags.kw_paren || last == csi_pkg::CH_EQ;
		end else if (ch == csi_pkg::CH_GT || ch == csi_pkg::CH_LT) begin
			rule = last_alnum;
		end else if (ch == csi_pkg::CH_LBRACE) begin
			rule = last == csi_pkg::CH_RPAREN || last == csi_pkg::CH_EQ;
		end else if (csi_pkg::is_alpha(ch)) begin
			rule = csi_pkg::in_ops_all(last) && !flags.deref && !flags.incdec;
		end else if (csi_pkg::is_digit(ch)) begin
			rule = csi_pkg::in_ops_digit(last);
		end else if (ch == csi_pkg::CH_PLUS) begin
			rule = last_alnum && !(last == csi_pkg::CH_LOWER_E && next_digit) &&
				!(next_present && next_ch == csi_pkg::CH_PLUS);
		end else if (ch == csi_pkg::CH_MINUS) begin
			rule = (last == csi_pkg::CH_RBRACK) ||
				(last_alnum && !(last == csi_pkg::CH_LOWER_E && next_digit) &&
				 !(next_present && (next_ch == csi_pkg::CH_GT ||
				                    next_ch == csi_pkg::CH_MINUS)));
		end else if (ch == csi_pkg::CH_EQ || ch == csi_pkg::CH_SLASH) begin
			rule = last_alnum || last == csi_pkg::CH_RBRACK;
		end else if (ch == csi_pkg::CH_AMP) begin
			rule = last == csi_pkg::CH_EQ || last == csi_pkg::CH_COMMA;
		end else begin
			rule = 1'b0;
		end
	end

	// include lines and non-normal modes pass through untouched
	assign need_space = flags.mode_normal && !flags.include_line && rule;

endmodule

>>> rtl/c_source_space_inserter_unit.sv
// ----------------------------------------------------------------------------
// c_source_space_inserter_unit
// Re-emits a C source byte stream, inserting a space before a byte where the
// spacing rules call for one.
//
// channel  dir  tdata fields (low bit up)                        tlast
// s_*      in   ch[7:0] next_ch[15:8] next_present[16] pad[23:17] -
// m_*      out  out_byte[7:0]                                     last_of_run
//
// One byte per cycle in steady state while m_tready holds; a byte that gets a
// space goes out as the space and then the byte, set by the single output register draining space then byte.
// An input transaction passes the input register and then the result register.
// Reset clears mode, line state and both stage valids; no clearing pass.
// A stalled output holds the input register, which then drops s_tready.
// ----------------------------------------------------------------------------
module c_source_space_inserter_unit #(
	parameter int unsigned WINDOW_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // ch[7:0], next_ch[15:8], next_present[16], zeros
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic        m_tlast    // last_of_run
);

	logic                 valid_s1;
	logic [7:0]           ch_s1;
	logic [7:0]           next_ch_s1;
	logic                 next_present_s1;
	logic                 out_vld_q;
	logic                 space_q;
	logic [7:0]           out_ch_q;
	logic                 out_free;
	logic                 advance;
	logic                 need_space;
	csi_pkg::line_flags_t flags;

	// output register frees up once the byte itself is taken
	assign out_free = !out_vld_q || (m_tready && !space_q);
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1           <= s_tdata[7:0];
			next_ch_s1      <= s_tdata[15:8];
			next_present_s1 <= s_tdata[16];
		end
	end

	csi_line_track #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_line_track (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.ch     (ch_s1),
		.flags  (flags)
	);

	csi_space_rules u_space_rules (
		.ch          (ch_s1),
		.next_ch     (next_ch_s1),
		.next_present(next_present_s1),
		.flags       (flags),
		.need_space  (need_space)
	);

	// result register: pending space, then the byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			space_q   <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
			space_q   <= need_space;
		end else if (out_vld_q && m_tready) begin
			if (space_q) begin
				space_q <= 1'b0;
			end else begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_ch_q <= ch_s1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = space_q ? csi_pkg::CH_SPACE : out_ch_q;
	assign m_tlast  = !space_q;

`ifndef SYNTHESIS
	// an inserted space is always followed by its byte
	a_space_then_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |=> m_tvalid)
		else $error("inserted space not followed by its byte");

	// a newline never gets a space in front
	a_no_space_before_lf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> out_ch_q != csi_pkg::CH_LF)
		else $error("space inserted before newline");

	// input stage only moves when the output register can take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> !out_vld_q || (m_tready && m_tlast))
		else $error("output register overwritten while holding a result");
`endif

endmodule
